>>> rtl/core/mbt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbt_pkg
// Shared constants, types and helpers for the memoized binomial table.
// ----------------------------------------------------------------------------
package mbt_pkg;

  localparam int MAX_ROWS    = 32;
  localparam int STORE_DEPTH = MAX_ROWS * (MAX_ROWS + 1) / 2;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int ROW_W       = 6;
  localparam int COEFF_W     = 31;
  localparam int PROD_W      = 2 * ROW_W + 1;

  typedef logic [ROW_W-1:0]   row_t;
  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [COEFF_W-1:0] coeff_t;

  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_BAD_COLUMN = 2'd1,
    STATUS_BAD_ROW    = 2'd2
  } status_t;

  typedef struct packed {
    logic   we;
    addr_t  waddr;
    coeff_t wdata;
    logic   re;
    addr_t  raddr;
  } mem_req_t;

  // first entry of row r: r*(r+1)/2
  function automatic addr_t row_base(input row_t r);
    logic [PROD_W-1:0] p;
    p = PROD_W'(r) * (PROD_W'(r) + PROD_W'(1));
    return ADDR_W'(p >> 1);
  endfunction

endpackage

>>> rtl/core/mbt_query_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbt_query_if
// Query channel: triangle row and column of the requested coefficient.
// ----------------------------------------------------------------------------
interface mbt_query_if;
  logic             valid;
  logic             ready;
  mbt_pkg::row_t    row_index;
  mbt_pkg::row_t    column_index;

  modport source (output valid, output row_index, output column_index, input ready);
  modport sink   (input valid, input row_index, input column_index, output ready);
endinterface

>>> rtl/core/mbt_result_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbt_result_if
// Result channel: binomial coefficient and status code.
// ----------------------------------------------------------------------------
interface mbt_result_if;
  logic             valid;
  logic             ready;
  mbt_pkg::coeff_t  coefficient;
  logic [1:0]       status;

  modport source (output valid, output coefficient, output status, input ready);
  modport sink   (input valid, input coefficient, input status, output ready);
endinterface

>>> rtl/core/mbt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mbt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/mbt_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbt_ctrl
// Query sequencer: fills missing triangle rows through the store, then reads
// the requested entry and holds the result in an output register.
// ----------------------------------------------------------------------------
module mbt_ctrl (
  input  logic              clk,
  input  logic              rst,
  mbt_query_if.sink         query,
  mbt_result_if.source      result,
  output mbt_pkg::mem_req_t mem_req,
  input  mbt_pkg::coeff_t   rd_data
);
  import mbt_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FILL,
    S_RESP
  } state_t;

  state_t  state;
  row_t    req_n;
  row_t    req_k;
  status_t req_status;
  logic    use_mem;
  row_t    rows_filled;
  row_t    fill_row;
  row_t    step;
  coeff_t  hold;
  logic    fwd_hit;
  coeff_t  fwd_data;
  logic    out_valid;
  coeff_t  out_coeff;
  status_t out_status;

  logic    accept;
  logic    in_range;
  logic    in_hit;
  logic    last_step;
  logic    out_load;
  addr_t   fill_base;
  coeff_t  fill_value;
  row_t    next_row;

  assign accept    = query.valid && query.ready;
  assign in_range  = query.row_index < ROW_W'(MAX_ROWS);
  assign in_hit    = in_range && (rows_filled > query.row_index);
  assign fill_base = row_base(fill_row);
  assign next_row  = ROW_W'(fill_row + ROW_W'(1));
  // row 0 ends at step 0; row r > 0 ends at step r+1 (writes lag reads)
  assign last_step = (fill_row == '0) ? (step == '0) : (step == next_row);
  assign out_load  = (state == S_RESP) && (!out_valid || result.ready);

  // edge entries are 1, inner ones the sum of the two entries above
  always_comb begin
    if (fill_row == '0 || step == ROW_W'(1) || step == next_row) begin
      fill_value = COEFF_W'(1);
    end else begin
      fill_value = COEFF_W'({1'b0, hold} + {1'b0, rd_data});
    end
  end

  always_comb begin
    mem_req = '0;
    case (state)
      S_IDLE: begin
        if (accept && in_hit && query.column_index <= query.row_index) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = ADDR_W'(row_base(query.row_index) + ADDR_W'(query.column_index));
        end
      end
      S_FILL: begin
        if (fill_row == '0) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = '0;
          mem_req.wdata = fill_value;
        end else begin
          if (step != '0) begin
            mem_req.we    = 1'b1;
            mem_req.waddr = ADDR_W'(fill_base + ADDR_W'(step) - ADDR_W'(1));
            mem_req.wdata = fill_value;
          end
          if (step < fill_row) begin
            mem_req.re    = 1'b1;
            mem_req.raddr = ADDR_W'(fill_base - ADDR_W'(fill_row) + ADDR_W'(step));
          end
        end
        if (last_step && !(fill_row < req_n) && req_k <= req_n) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = ADDR_W'(row_base(req_n) + ADDR_W'(req_k));
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      rows_filled <= '0;
      out_valid   <= 1'b0;
    end else begin
      // read data stays put in S_RESP: no reads are issued while waiting
      if (out_load) begin
        out_valid  <= 1'b1;
        out_coeff  <= use_mem ? (fwd_hit ? fwd_data : rd_data) : '0;
        out_status <= req_status;
      end else if (out_valid && result.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            req_n <= query.row_index;
            req_k <= query.column_index;
            if (!in_range) begin
              req_status <= STATUS_BAD_ROW;
              use_mem    <= 1'b0;
              state      <= S_RESP;
            end else if (!in_hit) begin
              fill_row <= rows_filled;
              step     <= '0;
              state    <= S_FILL;
            end else if (query.column_index > query.row_index) begin
              req_status <= STATUS_BAD_COLUMN;
              use_mem    <= 1'b0;
              state      <= S_RESP;
            end else begin
              req_status <= STATUS_OK;
              use_mem    <= 1'b1;
              fwd_hit    <= 1'b0;
              state      <= S_RESP;
            end
          end
        end
        S_FILL: begin
          if (step != '0 && step <= fill_row) begin
            hold <= rd_data;
          end
          if (last_step) begin
            rows_filled <= next_row;
            step        <= '0;
            if (fill_row < req_n) begin
              fill_row <= next_row;
            end else if (req_k > req_n) begin
              req_status <= STATUS_BAD_COLUMN;
              use_mem    <= 1'b0;
              state      <= S_RESP;
            end else begin
              req_status <= STATUS_OK;
              use_mem    <= 1'b1;
              // last entry of the row is written in the cycle it is read
              fwd_hit    <= (req_k == req_n);
              fwd_data   <= fill_value;
              state      <= S_RESP;
            end
          end else begin
            step <= ROW_W'(step + ROW_W'(1));
          end
        end
        S_RESP: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign query.ready        = (state == S_IDLE);
  assign result.valid       = out_valid;
  assign result.coefficient = out_coeff;
  assign result.status      = out_status;

endmodule

>>> rtl/core/memoized_binomial_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// memoized_binomial_table
// Pascal's triangle lookup: fills missing rows on demand into one store and
// answers each query with C(n,k) and a status code.
// ----------------------------------------------------------------------------
//   channel   dir   fields                         handshake
//   query     in    row_index[5:0], column_index   valid / ready
//   result    out   coefficient[30:0], status[1:0] valid / ready
//
// A query on a filled row, or one whose row is out of range, passes through
// S_RESP into the output register; a query on a missing row first fills
// each missing row, one store write per entry, with the single read port
// streaming the row above.
// One query at a time; a new query is accepted while a result waits in the
// output register. Reset clears the filled-row count; no clearing pass.
// ----------------------------------------------------------------------------
module memoized_binomial_table (
  input  logic          clk,
  input  logic          rst,
  mbt_query_if.sink     query,
  mbt_result_if.source  result
);
  import mbt_pkg::*;

  mem_req_t mem_req;
  coeff_t   rd_data;

  mbt_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .query   (query),
    .result  (result),
    .mem_req (mem_req),
    .rd_data (rd_data)
  );

  mbt_ram #(
    .WIDTH (COEFF_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .re    (mem_req.re),
    .raddr (mem_req.raddr),
    .rdata (rd_data)
  );

endmodule

>>> rtl/core/mbt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbt_checker
// Port-level checks for the memoized binomial table.
// ----------------------------------------------------------------------------
module mbt_checker (
  input logic             clk,
  input logic             rst,
  input logic             q_valid,
  input logic             q_ready,
  input logic             r_valid,
  input logic             r_ready,
  input mbt_pkg::coeff_t  r_coefficient,
  input logic [1:0]       r_status
);
  import mbt_pkg::*;

  // result held while stalled
  a_hold: assert property (@(posedge clk) disable iff (rst)
    r_valid && !r_ready |=> r_valid && $stable(r_coefficient) && $stable(r_status))
    else $error("result changed while stalled");

  // rejected requests carry a zero coefficient
  a_zero: assert property (@(posedge clk) disable iff (rst)
    r_valid && r_status != STATUS_OK |-> r_coefficient == '0)
    else $error("nonzero coefficient on rejected request");

  // one request in work at a time
  a_one: assert property (@(posedge clk) disable iff (rst)
    q_valid && q_ready |=> !q_ready)
    else $error("request accepted while busy");

  // no result appears without a request having been taken
  a_src: assert property (@(posedge clk) disable iff (rst)
    !r_valid ##1 r_valid |-> !$past(q_ready))
    else $error("result without request");

endmodule

bind memoized_binomial_table mbt_checker u_mbt_checker (
  .clk           (clk),
  .rst           (rst),
  .q_valid       (query.valid),
  .q_ready       (query.ready),
  .r_valid       (result.valid),
  .r_ready       (result.ready),
  .r_coefficient (result.coefficient),
  .r_status      (result.status)
);

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for memoized_binomial_table. A short table of requests
// covers the field extremes, both reject codes and on-demand row fills. A
// long random run follows. Results are checked against the table's value if
// given, else a Pascal's triangle predictor kept in step with accepted requests.
// ----------------------------------------------------------------------------
module tb;
  import mbt_pkg::*;

  localparam int RANDOM_COUNT   = 928;
  localparam int QUIET_COUNT    = 150;
  localparam int STALL_LIMIT    = 5000;
  localparam int DRAIN_CYCLES   = 10;
  localparam int DIRECTED_COUNT = 22;

  typedef struct packed {
    coeff_t  coefficient;
    status_t status;
  } binom_result_t;

  typedef struct {
    row_t    row;
    row_t    col;
    bit      known;
    coeff_t  coefficient;
    status_t status;
  } directed_request_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  mbt_query_if  query_ch ();
  mbt_result_if result_ch ();

  memoized_binomial_table uut (
    .clk    (clk),
    .rst    (rst),
    .query  (query_ch),
    .result (result_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predictor state: rows 0 .. rows_built-1 are valid
  logic [31:0]   pascal_store [MAX_ROWS][MAX_ROWS];
  int unsigned   rows_built = 0;
  binom_result_t pending_results [$];

  int      errors = 0;
  bit      quiet = 1'b0;
  bit      drv_known = 1'b0;
  coeff_t  drv_coeff = '0;
  status_t drv_status = STATUS_OK;
  int      stall_cycles = 0;

  // Row n counts from 0; k from 0. Missing rows are filled even when the
  // column is rejected.
  function automatic binom_result_t predict_binomial(input row_t n, input row_t k);
    binom_result_t r;
    int            cur;
    r.coefficient = '0;
    r.status      = STATUS_OK;
    if (int'(n) >= MAX_ROWS) begin
      r.status = STATUS_BAD_ROW;
    end else begin
      while (rows_built <= n) begin
        cur = int'(rows_built);
        for (int c = 0; c <= cur; c++) begin
          if (c == 0 || c == cur) begin
            pascal_store[cur][c] = 32'd1;
          end else begin
            pascal_store[cur][c] = pascal_store[cur-1][c-1] + pascal_store[cur-1][c];
          end
        end
        rows_built++;
      end
      if (k > n) begin
        r.status = STATUS_BAD_COLUMN;
      end else begin
        r.coefficient = pascal_store[n][k][COEFF_W-1:0];
      end
    end
    return r;
  endfunction

  directed_request_t directed_requests [DIRECTED_COUNT] = '{
    '{6'd63, 6'd63, 1'b1, 31'd0,  STATUS_BAD_ROW},     // nothing filled yet
    '{6'd32, 6'd0,  1'b1, 31'd0,  STATUS_BAD_ROW},     // first row past capacity
    '{6'd0,  6'd0,  1'b1, 31'd1,  STATUS_OK},
    '{6'd0,  6'd1,  1'b1, 31'd0,  STATUS_BAD_COLUMN},
    '{6'd1,  6'd1,  1'b1, 31'd1,  STATUS_OK},
    '{6'd2,  6'd1,  1'b1, 31'd2,  STATUS_OK},
    '{6'd4,  6'd63, 1'b1, 31'd0,  STATUS_BAD_COLUMN},  // still fills rows 3, 4
    '{6'd4,  6'd2,  1'b0, 31'd0,  STATUS_OK},
    '{6'd10, 6'd5,  1'b0, 31'd0,  STATUS_OK},
    '{6'd16, 6'd8,  1'b0, 31'd0,  STATUS_OK},
    '{6'd21, 6'd42, 1'b1, 31'd0,  STATUS_BAD_COLUMN},
    '{6'd20, 6'd10, 1'b0, 31'd0,  STATUS_OK},
    '{6'd31, 6'd0,  1'b1, 31'd1,  STATUS_OK},          // fills up to the last row
    '{6'd31, 6'd31, 1'b1, 31'd1,  STATUS_OK},
    '{6'd31, 6'd15, 1'b0, 31'd0,  STATUS_OK},          // largest coefficients
    '{6'd31, 6'd16, 1'b0, 31'd0,  STATUS_OK},
    '{6'd31, 6'd32, 1'b1, 31'd0,  STATUS_BAD_COLUMN},
    '{6'd31, 6'd30, 1'b1, 31'd31, STATUS_OK},
    '{6'd30, 6'd1,  1'b1, 31'd30, STATUS_OK},
    '{6'd48, 6'd21, 1'b1, 31'd0,  STATUS_BAD_ROW},
    '{6'd42, 6'd0,  1'b1, 31'd0,  STATUS_BAD_ROW},
    '{6'd0,  6'd63, 1'b1, 31'd0,  STATUS_BAD_COLUMN}
  };

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_request(input row_t n, input row_t k, input bit known,
                              input coeff_t coeff, input status_t st);
    int gap;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 5);
      query_ch.valid        <= 1'b0;
      query_ch.row_index    <= row_t'($urandom);
      query_ch.column_index <= row_t'($urandom);
      repeat (gap) @(negedge clk);
    end
    query_ch.valid        <= 1'b1;
    query_ch.row_index    <= n;
    query_ch.column_index <= k;
    drv_known  = known;
    drv_coeff  = coeff;
    drv_status = st;
    do @(posedge clk); while (!(query_ch.valid && query_ch.ready));
    @(negedge clk);
  endtask

  initial begin
    int   sink_hold;
    sink_hold       = 0;
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (sink_hold > 0) begin
        sink_hold--;
        result_ch.ready <= 1'b0;
      end else if (!quiet && !rst && $urandom_range(0, 5) == 0) begin
        sink_hold = $urandom_range(1, 5) - 1;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    binom_result_t want;
    if (!rst) begin
      if (result_ch.valid && result_ch.ready) begin
        if (pending_results.size() == 0) begin
          $error("result with no request pending: coefficient %0d status %0d",
                 result_ch.coefficient, result_ch.status);
          errors++;
        end else begin
          want = pending_results.pop_front();
          if (result_ch.coefficient !== want.coefficient) begin
            $error("coefficient: expected %0d, got %0d", want.coefficient,
                   result_ch.coefficient);
            errors++;
          end
          if (result_ch.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, result_ch.status);
            errors++;
          end
        end
      end
      if (query_ch.valid && query_ch.ready) begin
        want = predict_binomial(query_ch.row_index, query_ch.column_index);
        if (drv_known) begin
          want.coefficient = drv_coeff;
          want.status      = drv_status;
        end
        pending_results = {pending_results, want};
      end
    end
  end

  // watchdog: cycles with no handshake on either channel
  always @(posedge clk) begin
    if (rst || (query_ch.valid && query_ch.ready) ||
        (result_ch.valid && result_ch.ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    row_t n;
    row_t k;
    query_ch.valid        = 1'b0;
    query_ch.row_index    = '0;
    query_ch.column_index = '0;
    rst = 1'b1;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_requests[i]) begin
      send_request(directed_requests[i].row, directed_requests[i].col,
                   directed_requests[i].known, directed_requests[i].coefficient,
                   directed_requests[i].status);
    end

    for (int i = 0; i < RANDOM_COUNT; i++) begin
      quiet = (i >= RANDOM_COUNT - QUIET_COUNT);
      case ($urandom_range(0, 9))
        0, 1: begin
          n = row_t'($urandom);
          k = row_t'($urandom);
        end
        2: begin
          n = row_t'($urandom_range(MAX_ROWS, 63));
          k = row_t'($urandom);
        end
        3: begin
          n = row_t'($urandom_range(0, MAX_ROWS - 1));
          k = row_t'($urandom_range(int'(n) + 1, 63));
        end
        default: begin
          n = row_t'($urandom_range(0, MAX_ROWS - 1));
          k = row_t'($urandom_range(0, int'(n)));
        end
      endcase
      send_request(n, k, 1'b0, '0, STATUS_OK);
    end
    query_ch.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/mbt_pkg.sv
rtl/core/mbt_query_if.sv
rtl/core/mbt_result_if.sv
rtl/core/mbt_ram.sv
rtl/core/mbt_ctrl.sv
rtl/core/memoized_binomial_table.sv
rtl/core/mbt_checker.sv
tb/sv/tb.sv
